/* design/ipidf_pkg.sv */
// Shared types, register codes and helper functions of the filtered incremental PID block.
`timescale 1ns / 1ps

package ipidf_pkg;

	// Width of the shared multiplier operands and of its product.
	localparam int MulW  = 34;
	localparam int ProdW = 2 * MulW;
	// Width of the term accumulator.
	localparam int AccW  = 54;

	// Unity weight of the low-pass filters in Q1.16.
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Configuration register indexes.
	localparam logic [2:0] REG_GAIN_P      = 3'd0;
	localparam logic [2:0] REG_GAIN_I      = 3'd1;
	localparam logic [2:0] REG_GAIN_D      = 3'd2;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd3;
	localparam logic [2:0] REG_ERROR_ALPHA = 3'd4;
	localparam logic [2:0] REG_DERIV_ALPHA = 3'd5;
	localparam logic [2:0] REG_OUT_LOW     = 3'd6;
	localparam logic [2:0] REG_OUT_HIGH    = 3'd7;

	// Operation codes of an input word.
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] target;
		logic signed [31:0] measured;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] delta_out;
		logic               in_dead_band;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic        [30:0] dead_band;
		logic        [16:0] error_alpha;
		logic        [16:0] deriv_alpha;
		logic signed [31:0] out_low;
		logic signed [31:0] out_high;
	} cfg_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[AccW-1:31];
		hi_zeros = ~|x[AccW-1:31];
		if (hi_ones || hi_zeros) begin
			sat32 = x[31:0];
		end else if (x[AccW-1]) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = 32'sh7fff_ffff;
		end
	endfunction

	// A weight of zero or above unity acts as unity.
	function automatic logic [16:0] eff_alpha(input logic [16:0] a);
		if (a == 17'd0 || (a[16] && a[15:0] != 16'd0)) begin
			eff_alpha = ONE_Q16;
		end else begin
			eff_alpha = a;
		end
	endfunction

endpackage

/* design/ipidf_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ipidf_mul (
	input  logic                             clk,
	input  logic signed [ipidf_pkg::MulW-1:0]  a,
	input  logic signed [ipidf_pkg::MulW-1:0]  b,
	output logic signed [ipidf_pkg::ProdW-1:0] prod
);
	import ipidf_pkg::*;

	logic signed [ProdW-1:0] prod_q;

	// One product per cycle, available on the following cycle.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* design/ipidf_core.sv */
// Sequencer and datapath that run one controller step through the shared multiplier.
`timescale 1ns / 1ps

module ipidf_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipidf_pkg::cfg_t      cfg,
	input  logic                 start,
	input  ipidf_pkg::in_word_t  item,
	output logic                 idle,
	output logic                 done,
	input  logic                 res_free,
	output ipidf_pkg::out_word_t res
);
	import ipidf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EF    = 4'd1;
	localparam logic [3:0] S_EFW   = 4'd2;
	localparam logic [3:0] S_DB    = 4'd3;
	localparam logic [3:0] S_DF    = 4'd4;
	localparam logic [3:0] S_DFW   = 4'd5;
	localparam logic [3:0] S_P     = 4'd6;
	localparam logic [3:0] S_I     = 4'd7;
	localparam logic [3:0] S_D     = 4'd8;
	localparam logic [3:0] S_DW    = 4'd9;
	localparam logic [3:0] S_SAT   = 4'd10;
	localparam logic [3:0] S_CLAMP = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0] state_q;

	// Controller history.
	logic signed [31:0] fe_q;
	logic signed [31:0] pe_q;
	logic signed [31:0] pd_q;

	// Working registers of one step.
	logic signed [31:0]     raw_q;
	logic signed [32:0]     de_q;
	logic signed [31:0]     deriv_q;
	logic signed [32:0]     dd_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [31:0]     sum_q;
	out_word_t              res_q;

	logic signed [MulW-1:0]  mul_a;
	logic signed [MulW-1:0]  mul_b;
	logic signed [ProdW-1:0] prod;
	logic signed [AccW-1:0]  term;
	logic signed [AccW-1:0]  efw_sum;
	logic signed [AccW-1:0]  dfw_sum;
	logic signed [32:0]      fe_ext;
	logic signed [32:0]      fe_mag;
	logic                    dead;
	logic signed [32:0]      raw_diff;
	logic [16:0]             alpha_e;
	logic [16:0]             alpha_d;

	ipidf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Product divided by 65536 with floor rounding, sign-extended.
	assign term = {{(AccW - (ProdW - 16)){prod[ProdW-1]}}, prod[ProdW-1:16]};

	assign alpha_e = eff_alpha(cfg.error_alpha);
	assign alpha_d = eff_alpha(cfg.deriv_alpha);

	// Raw error as a 33-bit difference; it is saturated to 32 bits when registered.
	assign raw_diff = {item.target[31], item.target} - {item.measured[31], item.measured};

	// Filter outputs: previous value plus the scaled difference.
	assign efw_sum = term + {{(AccW - 32){fe_q[31]}}, fe_q};
	assign dfw_sum = term + {{(AccW - 32){pd_q[31]}}, pd_q};

	// Dead zone test on the filtered error magnitude.
	assign fe_ext = {fe_q[31], fe_q};
	assign fe_mag = fe_q[31] ? -fe_ext : fe_ext;
	assign dead   = fe_mag < {2'b00, cfg.dead_band};

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_EF: begin
				mul_a = {{(MulW - 17){1'b0}}, alpha_e};
				mul_b = {{2{raw_q[31]}}, raw_q} - {{2{fe_q[31]}}, fe_q};
			end
			S_DF: begin
				mul_a = {{(MulW - 17){1'b0}}, alpha_d};
				mul_b = {de_q[32], de_q} - {{2{pd_q[31]}}, pd_q};
			end
			S_P: begin
				mul_a = {{2{cfg.gain_p[31]}}, cfg.gain_p};
				mul_b = {de_q[32], de_q};
			end
			S_I: begin
				mul_a = {{2{cfg.gain_i[31]}}, cfg.gain_i};
				mul_b = {{2{fe_q[31]}}, fe_q};
			end
			S_D: begin
				mul_a = {{2{cfg.gain_d[31]}}, cfg.gain_d};
				mul_b = {dd_q[32], dd_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer and history registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fe_q    <= '0;
			pe_q    <= '0;
			pd_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (item.op == OP_CLEAR) begin
							fe_q    <= '0;
							pe_q    <= '0;
							pd_q    <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_EF;
						end
					end
				end
				S_EF: state_q <= S_EFW;
				S_EFW: begin
					fe_q    <= efw_sum[31:0];
					state_q <= S_DB;
				end
				S_DB: begin
					if (dead) begin
						pe_q    <= fe_q;
						pd_q    <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DF;
					end
				end
				S_DF:  state_q <= S_DFW;
				S_DFW: state_q <= S_P;
				S_P:   state_q <= S_I;
				S_I:   state_q <= S_D;
				S_D:   state_q <= S_DW;
				S_DW:  state_q <= S_SAT;
				S_SAT: state_q <= S_CLAMP;
				S_CLAMP: begin
					pe_q    <= fe_q;
					pd_q    <= deriv_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the step.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				raw_q <= sat32({{(AccW - 33){raw_diff[32]}}, raw_diff});
				res_q <= '0;
			end
			S_DB: begin
				de_q <= fe_ext - {pe_q[31], pe_q};
				if (dead) begin
					res_q.delta_out    <= '0;
					res_q.in_dead_band <= 1'b1;
				end
			end
			S_DFW: deriv_q <= sat32(dfw_sum);
			S_P:   dd_q    <= {deriv_q[31], deriv_q} - {pd_q[31], pd_q};
			S_I:   acc_q   <= term;
			S_D:   acc_q   <= acc_q + term;
			S_DW:  acc_q   <= acc_q + term;
			S_SAT: sum_q   <= sat32(acc_q);
			S_CLAMP: begin
				res_q.in_dead_band <= 1'b0;
				if (sum_q < cfg.out_low) begin
					res_q.delta_out <= cfg.out_low;
				end else if (sum_q > cfg.out_high) begin
					res_q.delta_out <= cfg.out_high;
				end else begin
					res_q.delta_out <= sum_q;
				end
			end
			default: ;
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_OUT);
	assign res  = res_q;

endmodule

/* design/incremental_pid_filtered.sv */
// Top level of the filtered incremental PID block: configuration registers and result register.
`timescale 1ns / 1ps

// Incremental PID controller with low-pass filtered error and derivative, Q16.16 throughout.
// Each input word yields exactly one result word. A compute word runs through the states
// EF, EFW, DB, DF, DFW, P, I, D, DW, SAT, CLAMP and OUT, and its result lands in the
// output register as ready rises again. A word whose filtered error falls in the dead
// zone goes from DB straight to OUT, and a clear word goes from idle straight to OUT.
// A held result stalls the core in OUT until it is taken. A compute word makes five
// sequential passes (two filter weights, three gains) through the single 34x34
// multiplier, each followed by its add or saturate step.
// The result register lets a new word be accepted while the previous result waits.
// Configuration is written through cfg_we/cfg_index/cfg_data and should change only
// while the block is idle.

module incremental_pid_filtered (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ipidf_pkg::in_word_t  item_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ipidf_pkg::out_word_t result_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import ipidf_pkg::*;

	cfg_t      cfg_q;
	logic      core_idle;
	logic      core_done;
	logic      res_free;
	out_word_t core_res;
	logic      out_valid_q;
	out_word_t out_word_q;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				REG_DEAD_BAND:   cfg_q.dead_band   <= cfg_data[30:0];
				REG_ERROR_ALPHA: cfg_q.error_alpha <= cfg_data[16:0];
				REG_DERIV_ALPHA: cfg_q.deriv_alpha <= cfg_data[16:0];
				REG_OUT_LOW:     cfg_q.out_low     <= cfg_data;
				REG_OUT_HIGH:    cfg_q.out_high    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_ready = core_idle;
	assign res_free   = !out_valid_q || result_ready;

	ipidf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (item_valid && core_idle),
		.item     (item_data),
		.idle     (core_idle),
		.done     (core_done),
		.res_free (res_free),
		.res      (core_res)
	);

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= core_done;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && core_done) begin
			out_word_q <= core_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_word_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the filtered incremental PID block with a built-in increment predictor.
`timescale 1ns / 1ps

module testbench;
	import ipidf_pkg::*;

	localparam longint S32_MAX = 64'sh7fff_ffff;
	localparam longint S32_MIN = -64'sh8000_0000;
	localparam longint UNITY = 65536;
	localparam int IDLE_PCT = 28;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_CAP = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_word_t item_data;
	logic result_valid;
	logic result_ready;
	out_word_t result_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	// Words waiting to be driven and increments waiting to come out.
	in_word_t pending_words[$];
	out_word_t expected_increments[$];

	// Predictor copy of the configuration and of the controller history.
	logic signed [31:0] kp = '0, ki = '0, kd = '0, lo_clamp = '0, hi_clamp = '0;
	logic [30:0] band = '0;
	logic [16:0] err_wt = '0, der_wt = '0;
	longint filt_err = 0, last_err = 0, last_deriv = 0;

	logic item_took = 1'b0;
	logic steady = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	incremental_pid_filtered i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint clip_s32(input longint x);
		if (x > S32_MAX) begin
			return S32_MAX;
		end
		if (x < S32_MIN) begin
			return S32_MIN;
		end
		return x;
	endfunction

	// A weight of zero or above unity behaves as unity.
	function automatic longint weight_of(input logic [16:0] a);
		if (a == 17'd0 || a > 17'h10000) begin
			return UNITY;
		end
		return longint'(a);
	endfunction

	// First-order low-pass: floor((w*x + (1-w)*prev) / 65536).
	function automatic longint low_pass(input longint w, input longint x, input longint prev);
		return (w * x + (UNITY - w) * prev) >>> 16;
	endfunction

	// Works out the increment of one word and advances the controller history.
	function automatic out_word_t pid_increment(input in_word_t w);
		out_word_t r;
		longint raw, err, mag, de, deriv, dd, sum;
		r.delta_out = '0;
		r.in_dead_band = 1'b0;
		if (w.op == OP_CLEAR) begin
			filt_err = 0;
			last_err = 0;
			last_deriv = 0;
			return r;
		end
		raw = clip_s32(longint'($signed(w.target)) - longint'($signed(w.measured)));
		err = low_pass(weight_of(err_wt), raw, filt_err);
		filt_err = err;
		mag = (err < 0) ? -err : err;
		// Inside the dead zone the history is aligned and the increment is zero.
		if (mag < longint'(band)) begin
			last_err = err;
			last_deriv = 0;
			r.in_dead_band = 1'b1;
			return r;
		end
		de = err - last_err;
		deriv = clip_s32(low_pass(weight_of(der_wt), de, last_deriv));
		dd = deriv - last_deriv;
		sum = ((longint'(kp) * de) >>> 16) + ((longint'(ki) * err) >>> 16)
			+ ((longint'(kd) * dd) >>> 16);
		sum = clip_s32(sum);
		// When the clamp is inverted, the lower bound wins for a sum below it and the upper bound otherwise.
		if (sum < longint'(lo_clamp)) begin
			sum = longint'(lo_clamp);
		end else if (sum > longint'(hi_clamp)) begin
			sum = longint'(hi_clamp);
		end
		last_err = err;
		last_deriv = deriv;
		r.delta_out = sum[31:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		mismatches++;
	endtask

	// Input driver: presents queued words and holds each one until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_took) begin
				if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					item_data <= pending_words.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Output monitor: checks each result word, predicts each accepted input word,
	// and ends the run when the handshakes stop moving.
	always @(posedge clk) begin : monitor
		out_word_t want;
		logic got_result;
		got_result = result_valid && result_ready;
		if (got_result) begin
			if (expected_increments.size() == 0) begin
				flag_mismatch($sformatf("result word %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = expected_increments.pop_front();
				if (result_data.delta_out !== want.delta_out) begin
					flag_mismatch($sformatf("word %0d delta_out got %h want %h", results_seen,
						result_data.delta_out, want.delta_out));
				end
				if (result_data.in_dead_band !== want.in_dead_band) begin
					flag_mismatch($sformatf("word %0d in_dead_band got %b want %b", results_seen,
						result_data.in_dead_band, want.in_dead_band));
				end
			end
			results_seen++;
		end
		item_took = item_valid && item_ready;
		if (item_took) begin
			expected_increments.push_back(pid_increment(item_data));
		end
		if (item_took || got_result) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_word(input logic op, input logic [31:0] t, input logic [31:0] m);
		in_word_t w;
		w.op = op;
		w.target = t;
		w.measured = m;
		pending_words.push_back(w);
	endtask

	// Waits until every queued word is in and every result is out, then lets the
	// block settle before the next register write.
	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || item_valid || expected_increments.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write per cycle; the caller stands at a falling edge.
	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [31:0] p, i, d, db, ea, da, lo, hi);
		put_reg(REG_GAIN_P, p);
		put_reg(REG_GAIN_I, i);
		put_reg(REG_GAIN_D, d);
		put_reg(REG_DEAD_BAND, db);
		put_reg(REG_ERROR_ALPHA, ea);
		put_reg(REG_DERIV_ALPHA, da);
		put_reg(REG_OUT_LOW, lo);
		put_reg(REG_OUT_HIGH, hi);
		cfg_we <= 1'b0;
		kp = p;
		ki = i;
		kd = d;
		band = db[30:0];
		err_wt = ea[16:0];
		der_wt = da[16:0];
		lo_clamp = lo;
		hi_clamp = hi;
	endtask

	// Mostly moderate gains so the sum stays in range, with the extremes now and then.
	function automatic logic [31:0] random_gain();
		logic [31:0] t;
		t = $urandom();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return {{14{t[31]}}, t[17:0]};
		endcase
	endfunction

	// Filter weights, with junk in the bits above the register.
	function automatic logic [31:0] random_weight();
		logic [31:0] t;
		t = $urandom();
		case ($urandom_range(5))
			0: t[16:0] = 17'd0;
			1: t[16:0] = 17'h10000;
			2: t[16:0] = 17'd1;
			3: t[16:0] = 17'($urandom_range(131071, 65537));
			default: t[16:0] = 17'($urandom_range(65535, 1));
		endcase
		return t;
	endfunction

	task automatic random_settings();
		logic [31:0] db, lo, hi, t;
		db = $urandom();
		case ($urandom_range(5))
			0: db[30:0] = 31'd0;
			1: db[30:0] = 31'h7fff_ffff;
			default: db[30:0] = 31'($urandom_range(131072));
		endcase
		case ($urandom_range(5))
			0: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
			end
			1: begin
				// Inverted clamp.
				hi = -32'($urandom_range(1 << 20));
				lo = 32'($urandom_range(1 << 20));
			end
			default: begin
				t = $urandom_range(1 << 24);
				lo = -t;
				hi = 32'($urandom_range(1 << 24));
			end
		endcase
		load_settings(random_gain(), random_gain(), random_gain(), db, random_weight(),
			random_weight(), lo, hi);
	endtask

	// Random words: mostly small errors around a random setpoint, some held inputs
	// so the filters settle, some extremes, and a few clears.
	task automatic queue_random_words(input int count);
		logic [31:0] t, m, prev_t, prev_m;
		int off;
		prev_t = $urandom();
		prev_m = prev_t;
		for (int n = 0; n < count; n++) begin
			t = $urandom();
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					off = int'($urandom_range(262144)) - 131072;
					m = t - off;
				end
				5, 6: begin
					t = prev_t;
					m = prev_m;
				end
				7: begin
					t = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
					m = $urandom();
				end
				default: m = $urandom();
			endcase
			push_word(($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP, t, m);
			prev_t = t;
			prev_m = m;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_data = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GAIN_P;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: unity weights, zero gains and a zero-width clamp.
		push_word(OP_STEP, 32'h0001_0000, 32'h0);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		drain();

		// Plain gains, narrow dead zone, full clamp range.
		load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h100, 32'h0,
			32'h8000, 32'h8000_0000, 32'h7fff_ffff);
		push_word(OP_STEP, 32'h0, 32'h0);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h8000_0000);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		push_word(OP_STEP, 32'h8000_0000, 32'h0);
		push_word(OP_CLEAR, 32'h1234_5678, 32'hedcb_a987);
		push_word(OP_STEP, 32'h80, 32'h0);
		push_word(OP_STEP, 32'h100, 32'h0);
		push_word(OP_STEP, 32'hffff_ff00, 32'h0);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h0);
		push_word(OP_CLEAR, 32'h7fff_ffff, 32'h8000_0000);
		drain();

		// Extreme gains, widest dead zone (bit 31 of the data set), weight above unity,
		// slowest derivative weight and an inverted clamp.
		load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
			32'h0001_ffff, 32'h1, 32'h0001_0000, 32'hffff_0000);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h8000_0000);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		push_word(OP_STEP, 32'h0, 32'h0);
		push_word(OP_STEP, 32'h1234_5678, 32'h1234_5678);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		push_word(OP_CLEAR, 32'h0, 32'hffff_ffff);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h8000_0000);
		drain();

		// Slowest error weight with no dead zone and a tight clamp.
		load_settings(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h1,
			32'h0001_0000, 32'hffff_8000, 32'h0000_8000);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h8000_0000);
		push_word(OP_STEP, 32'h7fff_ffff, 32'h8000_0000);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		push_word(OP_STEP, 32'h8000_0000, 32'h7fff_ffff);
		drain();

		// Random settings and words; one phase runs with no idling on either side.
		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			steady <= (phase == 2);
			queue_random_words(320);
			drain();
		end

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
